### hw/rtl/cda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_pkg - calendar date add/subtract shared definitions
// Field widths, calendar constants and the month length table.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int unsigned DaySpanBitsDef = 10;
  localparam int unsigned YearBitsDef    = 14;

  localparam int unsigned DayW        = 5;
  localparam int unsigned MonthW      = 4;
  localparam int unsigned SpanWeekW   = 6;
  localparam int unsigned SpanMonthW  = 8;
  localparam int unsigned SpanYearW   = 8;
  localparam int unsigned ResultYearW = 14;

  localparam int YearMax       = 9999;
  localparam int DaysPerWeek   = 7;
  localparam int MonthsPerYear = 12;
  localparam int LeapFebDays   = 29;
  localparam int LeapPeriod    = 4;
  localparam int LongMonth     = 31;
  localparam int unsigned LeapBits = $clog2(LeapPeriod);

  // Length of a month; a code outside 1..12 reads as a long month.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? DayW'(LeapFebDays) : DayW'(LeapFebDays - 1);
      4'd4, 4'd6, 4'd9, 4'd11:   len = DayW'(LongMonth - 1);
      default:                   len = DayW'(LongMonth);
    endcase
    return len;
  endfunction

endpackage : cda_pkg
`default_nettype wire

### hw/rtl/cda_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_if - request and response channels
// Valid/ready channels carrying a date request and its resulting date.
// ----------------------------------------------------------------------------
interface cda_req_if
  import cda_pkg::*;
#(
  parameter int unsigned DAY_SPAN_BITS = DaySpanBitsDef,
  parameter int unsigned YEAR_BITS     = YearBitsDef
);
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [DayW-1:0]          start_day;
  logic [MonthW-1:0]        start_month;
  logic [YEAR_BITS-1:0]     start_year;
  logic [DAY_SPAN_BITS-1:0] span_days;
  logic [SpanWeekW-1:0]     span_weeks;
  logic [SpanMonthW-1:0]    span_months;
  logic [SpanYearW-1:0]     span_years;

  modport source (output valid, operation, start_day, start_month, start_year,
                  span_days, span_weeks, span_months, span_years, input ready);
  modport sink   (input valid, operation, start_day, start_month, start_year,
                  span_days, span_weeks, span_months, span_years, output ready);
endinterface : cda_req_if

interface cda_rsp_if
  import cda_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [DayW-1:0]        result_day;
  logic [MonthW-1:0]      result_month;
  logic [ResultYearW-1:0] result_year;
  logic                   out_of_range;

  modport source (output valid, result_day, result_month, result_year, out_of_range,
                  input ready);
  modport sink   (input valid, result_day, result_month, result_year, out_of_range,
                  output ready);
endinterface : cda_rsp_if
`default_nettype wire

### hw/rtl/cda_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_alu - shared add/subtract unit
// Signed adder shared by the steps of the date sequencer.
// ----------------------------------------------------------------------------
module cda_alu #(
  parameter int unsigned W = 18
) (
  input  wire logic signed [W-1:0] a_i,
  input  wire logic signed [W-1:0] b_i,
  input  wire logic                sub_i,
  output logic signed [W-1:0]      y_o
);

  assign y_o = sub_i ? (a_i - b_i) : (a_i + b_i);

endmodule : cda_alu
`default_nettype wire

### hw/rtl/calendar_date_add_subtract_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_add_subtract_core - date plus/minus a span of days to years
// Sequencer around one shared adder; one request at a time.
// ----------------------------------------------------------------------------
// A request takes a start date and a span and returns one result date.
// Leap years are those divisible by four. Add applies years, months, weeks,
// then days; subtract applies days, weeks, months, then years and keeps the
// day number after the month and year steps. The year saturates to 0..9999
// with out_of_range set. All work runs through one adder, one step a cycle;
// a wrap step repeats once per twelve months wrapped and a normalise step
// once per month crossed by the day and week spans. The result is loaded
// in the last step and the request side is ready again in the cycle after.
// The request side is ready only while the sequencer is idle; a finished
// result sits in the output register until taken, and the next one waits
// in the last step while that register is full.
module calendar_date_add_subtract_core
  import cda_pkg::*;
#(
  parameter int unsigned DAY_SPAN_BITS = DaySpanBitsDef,
  parameter int unsigned YEAR_BITS     = YearBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cda_req_if.sink   req_i,
  cda_rsp_if.source rsp_o
);

  localparam int unsigned DW = ((DAY_SPAN_BITS > 9) ? DAY_SPAN_BITS : 9) + 2;
  localparam int unsigned YW = ((YEAR_BITS > ResultYearW) ? YEAR_BITS : ResultYearW) + 2;
  localparam int unsigned MW = SpanMonthW + 2;
  localparam int unsigned W  = (DW > YW) ? DW : YW;
  localparam int unsigned WeekDayW = SpanWeekW + 3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_A_YEAR, ST_A_FIXY, ST_A_MON, ST_A_MWRAP, ST_A_WEEK, ST_A_NORM_W,
    ST_A_DAY, ST_A_NORM_D, ST_S_DAY, ST_S_NORM_D, ST_S_WEEK, ST_S_NORM_W,
    ST_S_MON, ST_S_MWRAP, ST_S_YEAR, ST_SAT
  } state_e;

  state_e                   state_q, state_d;
  logic signed [DW-1:0]     d_q, d_d;
  logic signed [MW-1:0]     m_q, m_d;
  logic signed [YW-1:0]     y_q, y_d;
  logic [DAY_SPAN_BITS-1:0] days_q;
  logic [WeekDayW-1:0]      wdays_q;
  logic [SpanMonthW-1:0]    months_q;
  logic [SpanYearW-1:0]     years_q;

  logic                   rsp_valid_q;
  logic [DayW-1:0]        rsp_day_q;
  logic [MonthW-1:0]      rsp_month_q;
  logic [ResultYearW-1:0] rsp_year_q;
  logic                   rsp_oor_q;

  logic signed [W-1:0] alu_a, alu_b, alu_y;
  logic                alu_sub;

  logic                leap;
  logic                feb29_fix;
  logic                alu_pos;
  logic [MonthW-1:0]   prev_m;
  logic                out_free;
  logic                req_fire;

  assign leap      = (y_q[LeapBits-1:0] == '0);
  assign feb29_fix = !leap && (m_q == MW'(2)) && (d_q == DW'(LeapFebDays));
  assign alu_pos   = !alu_y[W-1] && (alu_y != '0);
  assign prev_m    = (m_q <= MW'(1)) ? MonthW'(MonthsPerYear) : MonthW'(m_q - MW'(1));
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign req_fire  = req_i.valid && req_i.ready;

  assign req_i.ready = (state_q == ST_IDLE);

  cda_alu #(.W(W)) u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sub_i(alu_sub),
    .y_o  (alu_y)
  );

  // Operand selection for the shared adder
  always_comb begin
    alu_a   = W'(d_q);
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      ST_A_YEAR: begin
        alu_a = W'(y_q);
        alu_b = W'(years_q);
      end
      ST_S_YEAR: begin
        alu_a   = W'(y_q);
        alu_b   = W'(years_q);
        alu_sub = 1'b1;
      end
      ST_A_MON: begin
        alu_a = W'(m_q);
        alu_b = W'(months_q);
      end
      ST_S_MON: begin
        alu_a   = W'(m_q);
        alu_b   = W'(months_q);
        alu_sub = 1'b1;
      end
      ST_A_MWRAP: begin
        alu_a   = W'(m_q);
        alu_b   = W'(MonthsPerYear);
        alu_sub = 1'b1;
      end
      ST_S_MWRAP: begin
        alu_a = W'(m_q);
        alu_b = W'(MonthsPerYear);
      end
      ST_A_WEEK: alu_b = W'(wdays_q);
      ST_A_DAY:  alu_b = W'(days_q);
      ST_S_WEEK: begin
        alu_b   = W'(wdays_q);
        alu_sub = 1'b1;
      end
      ST_S_DAY: begin
        alu_b   = W'(days_q);
        alu_sub = 1'b1;
      end
      ST_A_NORM_W, ST_A_NORM_D: begin
        alu_b   = W'(month_len(m_q[MonthW-1:0], leap));
        alu_sub = 1'b1;
      end
      ST_S_NORM_W, ST_S_NORM_D: begin
        // prior month is December only on a year wrap, so the leap bit is moot there
        alu_b = W'(month_len(prev_m, leap));
      end
      default: begin
        alu_a = W'(d_q);
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    d_d     = d_q;
    m_d     = m_q;
    y_d     = y_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          d_d = (req_i.start_day == '0) ? DW'(1) : DW'(req_i.start_day);
          if (req_i.start_month == '0) begin
            m_d = MW'(1);
          end else if (req_i.start_month > MonthW'(MonthsPerYear)) begin
            m_d = MW'(MonthsPerYear);
          end else begin
            m_d = MW'(req_i.start_month);
          end
          y_d     = YW'(req_i.start_year);
          state_d = req_i.operation ? ST_S_DAY : ST_A_YEAR;
        end
      end
      ST_A_YEAR: begin
        y_d     = alu_y[YW-1:0];
        state_d = ST_A_FIXY;
      end
      ST_A_FIXY: begin
        if (feb29_fix) begin
          m_d = MW'(3);
          d_d = DW'(1);
        end
        state_d = ST_A_MON;
      end
      ST_A_MON: begin
        m_d     = alu_y[MW-1:0];
        state_d = ST_A_MWRAP;
      end
      ST_A_MWRAP: begin
        if (m_q > MW'(MonthsPerYear)) begin
          m_d = alu_y[MW-1:0];
          y_d = y_q + YW'(1);
        end else begin
          if (feb29_fix) begin
            m_d = MW'(3);
            d_d = DW'(1);
          end
          state_d = ST_A_WEEK;
        end
      end
      ST_A_WEEK: begin
        d_d     = alu_y[DW-1:0];
        state_d = ST_A_NORM_W;
      end
      ST_A_DAY: begin
        d_d     = alu_y[DW-1:0];
        state_d = ST_A_NORM_D;
      end
      ST_A_NORM_W, ST_A_NORM_D: begin
        if (alu_pos) begin
          d_d = alu_y[DW-1:0];
          if (m_q >= MW'(MonthsPerYear)) begin
            m_d = MW'(1);
            y_d = y_q + YW'(1);
          end else begin
            m_d = m_q + MW'(1);
          end
        end else begin
          state_d = (state_q == ST_A_NORM_W) ? ST_A_DAY : ST_SAT;
        end
      end
      ST_S_DAY: begin
        d_d     = alu_y[DW-1:0];
        state_d = ST_S_NORM_D;
      end
      ST_S_WEEK: begin
        d_d     = alu_y[DW-1:0];
        state_d = ST_S_NORM_W;
      end
      ST_S_NORM_D, ST_S_NORM_W: begin
        if (d_q <= DW'(0)) begin
          d_d = alu_y[DW-1:0];
          m_d = MW'(prev_m);
          if (m_q <= MW'(1)) begin
            y_d = y_q - YW'(1);
          end
        end else begin
          state_d = (state_q == ST_S_NORM_D) ? ST_S_WEEK : ST_S_MON;
        end
      end
      ST_S_MON: begin
        m_d     = alu_y[MW-1:0];
        state_d = ST_S_MWRAP;
      end
      ST_S_MWRAP: begin
        if (m_q <= MW'(0)) begin
          m_d = alu_y[MW-1:0];
          y_d = y_q - YW'(1);
        end else begin
          state_d = ST_S_YEAR;
        end
      end
      ST_S_YEAR: begin
        y_d     = alu_y[YW-1:0];
        state_d = ST_SAT;
      end
      ST_SAT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SAT && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    d_q <= d_d;
    m_q <= m_d;
    y_q <= y_d;
    if (req_fire) begin
      days_q   <= req_i.span_days;
      wdays_q  <= WeekDayW'(req_i.span_weeks) * WeekDayW'(DaysPerWeek);
      months_q <= req_i.span_months;
      years_q  <= req_i.span_years;
    end
    if (state_q == ST_SAT && out_free) begin
      rsp_day_q   <= d_q[DayW-1:0];
      rsp_month_q <= m_q[MonthW-1:0];
      if (y_q[YW-1]) begin
        rsp_year_q <= '0;
        rsp_oor_q  <= 1'b1;
      end else if (y_q > YW'(YearMax)) begin
        rsp_year_q <= ResultYearW'(YearMax);
        rsp_oor_q  <= 1'b1;
      end else begin
        rsp_year_q <= y_q[ResultYearW-1:0];
        rsp_oor_q  <= 1'b0;
      end
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.result_day   = rsp_day_q;
  assign rsp_o.result_month = rsp_month_q;
  assign rsp_o.result_year  = rsp_year_q;
  assign rsp_o.out_of_range = rsp_oor_q;

  a_result_from_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == ST_SAT)
    else $error("result valid without a finished sequence");

  a_req_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q != ST_IDLE)
    else $error("accepted request did not start the sequencer");

  a_month_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_month_q >= MonthW'(1)) && (rsp_month_q <= MonthW'(MonthsPerYear)))
    else $error("result month out of range");

  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> rsp_day_q != '0)
    else $error("result day is zero");

  a_sat_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_oor_q) |->
      (rsp_year_q == '0) || (rsp_year_q == ResultYearW'(YearMax)))
    else $error("saturated year not at a bound");

endmodule : calendar_date_add_subtract_core
`default_nettype wire
